// ===== design/ale_pkg.sv =====
package ale_pkg;

    localparam int VAL_W = 64;
    localparam int X_W   = 32;
    localparam int DEG_W = 4;
    localparam int ORD_W = 5;
    // small integer factors: up to 2*l for the largest supported degree
    localparam int K_W   = 5;
    localparam int CNT_W = 6;
    localparam int RT_W  = 62;

    localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(30);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(63);

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_RATIO,
        DP_SQ_INIT,
        DP_SQ_STEP,
        DP_MQ_HI,
        DP_MQ_LO,
        DP_MINT,
        DP_NEG,
        DP_SAVE_P0,
        DP_SAVE_P1,
        DP_ACC_P0,
        DP_SWAP_B,
        DP_SUB,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_FIN,
        DP_SHIFT,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t          op;
        logic [K_W-1:0]  k;
        logic            q_is_x;
        logic            use_ratio;
        logic            bad;
    } dp_cmd_t;

    typedef struct packed {
        logic iter_last;
        logic x_bad;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RATIO,
        S_SQ_INIT,
        S_SQRT,
        S_PMM_HI,
        S_PMM_LO,
        S_PMM_MUL,
        S_PMM_NEG,
        S_P1_SAVE0,
        S_P1_HI,
        S_P1_LO,
        S_P1_MUL,
        S_P1_SAVE1,
        S_RC_B,
        S_RC_BMUL,
        S_RC_SWAP,
        S_RC_HI,
        S_RC_LO,
        S_RC_AMUL,
        S_RC_SUB,
        S_RC_DINIT,
        S_RC_DIV,
        S_RC_DFIN,
        S_RC_SHIFT,
        S_SC_DINIT,
        S_SC_DIV,
        S_SC_DFIN,
        S_SC_NEG,
        S_DONE
    } ctrl_state_t;

endpackage

// ===== design/ale_datapath.sv =====
module ale_datapath #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ale_pkg::dp_cmd_t              cmd,
    output ale_pkg::dp_stat_t             stat,
    input  logic signed [ale_pkg::X_W-1:0] s_x_value,
    output logic signed [ale_pkg::VAL_W-1:0] m_poly_value,
    output logic                          m_bad_args
);
    import ale_pkg::*;

    localparam logic [VAL_W-1:0] MIN_V = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] MAX_V = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] ONE_V = VAL_W'(1) << FRACTION_BITS;

    function automatic logic [VAL_W-1:0] sat_mag(input logic neg, input logic [69:0] mag);
        if (neg) begin
            if (mag >= 70'(MIN_V)) return MIN_V;
            return VAL_W'(0) - mag[VAL_W-1:0];
        end
        if (mag > 70'(MAX_V)) return MAX_V;
        return mag[VAL_W-1:0];
    endfunction

    logic signed [X_W-1:0]   x_reg;
    logic [VAL_W-1:0]        acc_reg, acc_next;
    logic [VAL_W-1:0]        p0_reg, p0_next;
    logic [VAL_W-1:0]        p1_reg, p1_next;
    logic [VAL_W-1:0]        b_reg, b_next;
    logic [VAL_W-1:0]        ratio_reg, ratio_next;
    logic [62:0]             ph_reg, ph_next;
    logic [30:0]             mq_reg, mq_next;
    logic                    mneg_reg, mneg_next;
    logic [RT_W-1:0]         op_reg, op_next, res_reg, res_next, one_reg, one_next;
    logic [VAL_W-1:0]        quo_reg, quo_next, dvs_reg, dvs_next;
    logic [VAL_W:0]          rem_reg, rem_next;
    logic                    dneg_reg, dneg_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [VAL_W-1:0]        poly_reg, poly_next;
    logic                    bad_reg, bad_next;

    logic [VAL_W-1:0]        mag_acc;
    logic [X_W-1:0]          mag_x;
    logic [30:0]             mq_sel;
    logic [62:0]             pl;
    logic [VAL_W-1:0]        r_sum;
    logic [69:0]             kprod;
    logic [VAL_W:0]          diff;
    logic signed [VAL_W-1:0] x_sq;
    logic [RT_W-1:0]         trial;
    logic [VAL_W:0]          rem_sh;
    logic [VAL_W-1:0]        dvs_sel;

    assign mag_acc = acc_reg[VAL_W-1] ? VAL_W'(0) - acc_reg : acc_reg;
    assign mag_x   = x_reg[X_W-1] ? X_W'(0) - X_W'(x_reg) : X_W'(x_reg);
    assign mq_sel  = cmd.q_is_x ? mag_x[30:0] : res_reg[30:0];
    assign pl      = mag_acc[31:0] * mq_reg;
    assign r_sum   = {ph_reg[61:0], 2'b00} + VAL_W'((64'(pl) + 64'd536870912) >> 30);
    assign kprod   = 70'(mag_acc) * 70'(cmd.k);
    assign diff    = {acc_reg[VAL_W-1], acc_reg} - {b_reg[VAL_W-1], b_reg};
    assign x_sq    = x_reg * x_reg;
    assign trial   = res_reg + one_reg;
    assign rem_sh  = {rem_reg[VAL_W-1:0], quo_reg[VAL_W-1]};
    assign dvs_sel = cmd.use_ratio ? ratio_reg : VAL_W'(cmd.k);

    assign stat.iter_last = (cnt_reg == '0);
    assign stat.x_bad = (s_x_value > 32'sh4000_0000) || (s_x_value < -32'sh4000_0000);

    always_comb begin
        acc_next   = acc_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        b_next     = b_reg;
        ratio_next = ratio_reg;
        ph_next    = ph_reg;
        mq_next    = mq_reg;
        mneg_next  = mneg_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        one_next   = one_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        dneg_next  = dneg_reg;
        cnt_next   = cnt_reg;
        poly_next  = poly_reg;
        bad_next   = bad_reg;
        unique case (cmd.op)
            DP_LOAD: begin
                acc_next   = ONE_V;
                ratio_next = VAL_W'(1);
            end
            DP_RATIO:   ratio_next = VAL_W'(70'(ratio_reg) * 70'(cmd.k));
            DP_SQ_INIT: begin
                op_next  = RT_W'((64'd1 << 60) - 64'(x_sq));
                res_next = '0;
                one_next = RT_W'(1) << 60;
                cnt_next = SQRT_STEPS;
            end
            DP_SQ_STEP: begin
                if (op_reg >= trial) begin
                    op_next  = op_reg - trial;
                    res_next = (res_reg >> 1) + one_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                one_next = one_reg >> 2;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            DP_MQ_HI: begin
                ph_next   = mag_acc[63:32] * mq_sel;
                mq_next   = mq_sel;
                mneg_next = acc_reg[VAL_W-1] ^ (cmd.q_is_x & x_reg[X_W-1]);
            end
            DP_MQ_LO:   acc_next = sat_mag(mneg_reg, 70'(r_sum));
            DP_MINT:    acc_next = sat_mag(acc_reg[VAL_W-1], kprod);
            DP_NEG:     acc_next = (acc_reg == MIN_V) ? MAX_V : VAL_W'(0) - acc_reg;
            DP_SAVE_P0: p0_next = acc_reg;
            DP_SAVE_P1: p1_next = acc_reg;
            DP_ACC_P0:  acc_next = p0_reg;
            DP_SWAP_B: begin
                b_next   = acc_reg;
                acc_next = p1_reg;
            end
            DP_SUB: begin
                if (diff[VAL_W] != diff[VAL_W-1]) acc_next = diff[VAL_W] ? MIN_V : MAX_V;
                else acc_next = diff[VAL_W-1:0];
            end
            DP_DIV_INIT: begin
                quo_next  = mag_acc + (dvs_sel >> 1);
                dvs_next  = dvs_sel;
                rem_next  = '0;
                dneg_next = acc_reg[VAL_W-1];
                cnt_next  = DIV_STEPS;
            end
            DP_DIV_STEP: begin
                if (rem_sh >= {1'b0, dvs_reg}) begin
                    rem_next = rem_sh - {1'b0, dvs_reg};
                    quo_next = {quo_reg[VAL_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[VAL_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            DP_DIV_FIN: acc_next = sat_mag(dneg_reg, 70'(quo_reg));
            DP_SHIFT: begin
                p0_next = p1_reg;
                p1_next = acc_reg;
            end
            DP_OUT: begin
                poly_next = cmd.bad ? '0 : acc_reg;
                bad_next  = cmd.bad;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_LOAD) x_reg <= s_x_value;
        acc_reg   <= acc_next;
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
        b_reg     <= b_next;
        ratio_reg <= ratio_next;
        ph_reg    <= ph_next;
        mq_reg    <= mq_next;
        mneg_reg  <= mneg_next;
        op_reg    <= op_next;
        res_reg   <= res_next;
        one_reg   <= one_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        rem_reg   <= rem_next;
        dneg_reg  <= dneg_next;
        poly_reg  <= poly_next;
        bad_reg   <= bad_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign m_poly_value = poly_reg;
    assign m_bad_args   = bad_reg;

endmodule

// ===== design/ale_ctrl.sv =====
module ale_ctrl #(
    parameter int MAX_DEGREE = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ale_pkg::DEG_W-1:0]        s_degree,
    input  logic signed [ale_pkg::ORD_W-1:0] s_order,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ale_pkg::dp_cmd_t                 cmd,
    input  ale_pkg::dp_stat_t                stat
);
    import ale_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic [K_W-1:0]   l_reg, l_next;
    logic [K_W-1:0]   am_reg, am_next;
    logic [K_W-1:0]   kk_reg, kk_next;
    logic             npos_reg, npos_next;
    logic             bad_reg, bad_next;
    logic             mv_reg, mv_next;

    logic [K_W-1:0]   in_l, in_am;
    logic             in_bad;
    logic             out_free;
    ctrl_state_t      after_pmm, scale_or_done;

    assign in_l   = K_W'(s_degree);
    assign in_am  = s_order[ORD_W-1] ? K_W'(-s_order) : K_W'(s_order);
    assign in_bad = (in_am > in_l) || stat.x_bad || (in_l > K_W'(MAX_DEGREE));
    assign out_free = !mv_reg || m_ready;
    assign scale_or_done = (npos_reg && am_reg != '0) ? S_SC_DINIT : S_DONE;
    assign after_pmm = (l_reg == am_reg) ? scale_or_done : S_P1_SAVE0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        l_reg    <= l_next;
        am_reg   <= am_next;
        kk_reg   <= kk_next;
        npos_reg <= npos_next;
        bad_reg  <= bad_next;
    end

    always_comb begin
        state_next    = state_reg;
        l_next        = l_reg;
        am_next       = am_reg;
        kk_next       = kk_reg;
        npos_next     = npos_reg;
        bad_next      = bad_reg;
        mv_next       = m_ready ? 1'b0 : mv_reg;
        cmd           = '0;
        cmd.op        = DP_NOP;
        s_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op    = DP_LOAD;
                    l_next    = in_l;
                    am_next   = in_am;
                    npos_next = s_order[ORD_W-1] || (s_order == '0);
                    bad_next  = in_bad;
                    kk_next   = in_l - in_am + K_W'(1);
                    if (in_bad) state_next = S_DONE;
                    else if (in_am == '0) state_next = (in_l == '0) ? S_DONE : S_P1_SAVE0;
                    else if (s_order[ORD_W-1]) state_next = S_RATIO;
                    else state_next = S_SQ_INIT;
                end
            end
            S_RATIO: begin
                cmd.op  = DP_RATIO;
                cmd.k   = kk_reg;
                kk_next = kk_reg + K_W'(1);
                if (kk_reg == l_reg + am_reg) state_next = S_SQ_INIT;
            end
            S_SQ_INIT: begin
                cmd.op     = DP_SQ_INIT;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op  = DP_SQ_STEP;
                kk_next = K_W'(1);
                if (stat.iter_last) state_next = S_PMM_HI;
            end
            S_PMM_HI: begin
                cmd.op     = DP_MQ_HI;
                state_next = S_PMM_LO;
            end
            S_PMM_LO: begin
                cmd.op     = DP_MQ_LO;
                state_next = S_PMM_MUL;
            end
            S_PMM_MUL: begin
                cmd.op     = DP_MINT;
                cmd.k      = K_W'({kk_reg, 1'b0} - 6'd1);
                state_next = S_PMM_NEG;
            end
            S_PMM_NEG: begin
                cmd.op  = DP_NEG;
                kk_next = kk_reg + K_W'(1);
                state_next = (kk_reg == am_reg) ? after_pmm : S_PMM_HI;
            end
            S_P1_SAVE0: begin
                cmd.op     = DP_SAVE_P0;
                state_next = S_P1_HI;
            end
            S_P1_HI: begin
                cmd.op     = DP_MQ_HI;
                cmd.q_is_x = 1'b1;
                state_next = S_P1_LO;
            end
            S_P1_LO: begin
                cmd.op     = DP_MQ_LO;
                state_next = S_P1_MUL;
            end
            S_P1_MUL: begin
                cmd.op     = DP_MINT;
                cmd.k      = K_W'({am_reg, 1'b1});
                state_next = S_P1_SAVE1;
            end
            S_P1_SAVE1: begin
                cmd.op  = DP_SAVE_P1;
                kk_next = am_reg + K_W'(2);
                state_next = (l_reg == am_reg + K_W'(1)) ? scale_or_done : S_RC_B;
            end
            S_RC_B: begin
                cmd.op     = DP_ACC_P0;
                state_next = S_RC_BMUL;
            end
            S_RC_BMUL: begin
                cmd.op     = DP_MINT;
                cmd.k      = kk_reg + am_reg - K_W'(1);
                state_next = S_RC_SWAP;
            end
            S_RC_SWAP: begin
                cmd.op     = DP_SWAP_B;
                state_next = S_RC_HI;
            end
            S_RC_HI: begin
                cmd.op     = DP_MQ_HI;
                cmd.q_is_x = 1'b1;
                state_next = S_RC_LO;
            end
            S_RC_LO: begin
                cmd.op     = DP_MQ_LO;
                state_next = S_RC_AMUL;
            end
            S_RC_AMUL: begin
                cmd.op     = DP_MINT;
                cmd.k      = K_W'({kk_reg, 1'b0} - 6'd1);
                state_next = S_RC_SUB;
            end
            S_RC_SUB: begin
                cmd.op     = DP_SUB;
                state_next = S_RC_DINIT;
            end
            S_RC_DINIT: begin
                cmd.op     = DP_DIV_INIT;
                cmd.k      = kk_reg - am_reg;
                state_next = S_RC_DIV;
            end
            S_RC_DIV: begin
                cmd.op = DP_DIV_STEP;
                if (stat.iter_last) state_next = S_RC_DFIN;
            end
            S_RC_DFIN: begin
                cmd.op     = DP_DIV_FIN;
                state_next = S_RC_SHIFT;
            end
            S_RC_SHIFT: begin
                cmd.op  = DP_SHIFT;
                kk_next = kk_reg + K_W'(1);
                state_next = (kk_reg == l_reg) ? scale_or_done : S_RC_B;
            end
            S_SC_DINIT: begin
                cmd.op        = DP_DIV_INIT;
                cmd.use_ratio = 1'b1;
                state_next    = S_SC_DIV;
            end
            S_SC_DIV: begin
                cmd.op = DP_DIV_STEP;
                if (stat.iter_last) state_next = S_SC_DFIN;
            end
            S_SC_DFIN: begin
                cmd.op     = DP_DIV_FIN;
                state_next = am_reg[0] ? S_SC_NEG : S_DONE;
            end
            S_SC_NEG: begin
                cmd.op     = DP_NEG;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.op     = DP_OUT;
                    cmd.bad    = bad_reg;
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid = mv_reg;

endmodule

// ===== design/associated_legendre_eval.sv =====
// associated legendre evaluator, P_l^m(x) in fixed point
// input beat: s_degree (l), s_order (signed m), s_x_value (x in Q1.30),
// taken on s_valid & s_ready; s_ready is high only while the sequencer idles
// result beat: m_poly_value (Q.FRACTION_BITS, saturated) and m_bad_args,
// offered on m_valid and held in an output register until m_ready
// one item at a time; with a = |m|, an item runs through these steps in order:
//   bad arguments: no computation, straight to the result
//   otherwise the factorial ratio (negative m only), the square root (a > 0),
//   P_a^a, P_a+1^a (l > a), the recurrence up to l, then for negative m
//   the scaling division, plus a negation for odd a
// the steps use the shared one-bit-per-cycle divider (64 steps per
// division) and the one-bit-per-cycle square root (31 steps)
// a new beat is taken while the previous result still waits in the
// output register; a stalled receiver only holds the sequencer at its
// last step once a second result is ready
// reset (aresetn low, synchronous) returns the sequencer to idle and
// drops m_valid; nothing else needs clearing
module associated_legendre_eval #(
    parameter int MAX_DEGREE    = 8,
    parameter int FRACTION_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ale_pkg::DEG_W-1:0]           s_degree,
    input  logic signed [ale_pkg::ORD_W-1:0]    s_order,
    input  logic signed [ale_pkg::X_W-1:0]      s_x_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ale_pkg::VAL_W-1:0]    m_poly_value,
    output logic                                m_bad_args
);
    import ale_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ale_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_degree (s_degree),
        .s_order  (s_order),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ale_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_x_value    (s_x_value),
        .m_poly_value (m_poly_value),
        .m_bad_args   (m_bad_args)
    );

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ale_pkg::*;

    localparam int MAX_DEG = 8;
    localparam int FRAC    = 32;
    localparam logic signed [63:0] VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] VMIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [DEG_W-1:0]        l;
        logic signed [ORD_W-1:0] m;
        logic signed [X_W-1:0]   x;
    } ale_arg_t;

    typedef struct {
        logic signed [VAL_W-1:0] v;
        logic                    bad;
    } ale_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [DEG_W-1:0] s_degree = '0;
    logic signed [ORD_W-1:0] s_order = '0;
    logic signed [X_W-1:0] s_x_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [VAL_W-1:0] m_poly_value;
    logic m_bad_args;

    associated_legendre_eval #(.MAX_DEGREE(MAX_DEG), .FRACTION_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_degree(s_degree), .s_order(s_order), .s_x_value(s_x_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_poly_value(m_poly_value), .m_bad_args(m_bad_args)
    );

    ale_arg_t arg_q[$];
    ale_res_t legendre_q[$];
    int mismatches = 0;
    bit hold_tx = 0;
    bit acc_seen = 0;
    int burst_left = 0;
    int gap_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [63:0] from_mag(bit neg, logic [63:0] mag);
        if (neg) begin
            if (mag >= 64'h8000_0000_0000_0000) return VMIN;
            return -$signed(mag);
        end
        if (mag > 64'h7FFF_FFFF_FFFF_FFFF) return VMAX;
        return $signed(mag);
    endfunction

    function automatic logic [63:0] mag_of(logic signed [63:0] v);
        return v < 0 ? 64'd0 - v : v;
    endfunction

    function automatic logic signed [63:0] neg_s(logic signed [63:0] v);
        return v == VMIN ? VMAX : -v;
    endfunction

    function automatic logic signed [63:0] mulq(logic signed [63:0] v,
                                                logic signed [63:0] q);
        logic [63:0] mv, mq, ph, pl, r;
        mv = mag_of(v);
        mq = mag_of(q);
        ph = (mv >> 32) * mq;
        pl = (mv & 64'hFFFF_FFFF) * mq;
        r = (ph << 2) + ((pl + (64'd1 << 29)) >> 30);
        return from_mag((v < 0) != (q < 0), r);
    endfunction

    function automatic logic signed [63:0] mulk(logic signed [63:0] v, logic [63:0] k);
        logic [63:0] mv;
        mv = mag_of(v);
        if (k == 0 || mv == 0) return 0;
        if (mv > 64'hFFFF_FFFF_FFFF_FFFF / k) return from_mag(v < 0, '1);
        return from_mag(v < 0, mv * k);
    endfunction

    function automatic logic signed [63:0] divk(logic signed [63:0] v, logic [63:0] k);
        if (k == 0) return v;
        return from_mag(v < 0, (mag_of(v) + k / 2) / k);
    endfunction

    function automatic logic signed [63:0] subs(logic signed [63:0] a,
                                                logic signed [63:0] b);
        logic signed [64:0] d;
        d = 65'(a) - 65'(b);
        if (d > 65'(VMAX)) return VMAX;
        if (d < 65'(VMIN)) return VMIN;
        return d[63:0];
    endfunction

    function automatic logic [63:0] fact(int n);
        logic [63:0] f;
        f = 1;
        for (int i = 2; i <= n; i++) f = f * i;
        return f;
    endfunction

    function automatic ale_res_t legendre_value(ale_arg_t a);
        ale_res_t r;
        int l, m, am;
        logic signed [63:0] x, root, pmm, p1, ta, tb, p;
        logic [63:0] n, rt, t, bitv, f;
        l = a.l;
        m = a.m;
        am = m < 0 ? -m : m;
        x = a.x;
        r.v = 0;
        r.bad = 0;
        if (am > l || x > (64'sd1 <<< 30) || x < -(64'sd1 <<< 30) ||
                l > MAX_DEG || l + am >= 21) begin
            r.bad = 1;
            return r;
        end
        pmm = 64'sd1 <<< FRAC;
        if (am > 0) begin
            n = (64'd1 << 60) - 64'(x * x);
            rt = 0;
            bitv = 64'd1 << 30;
            while (bitv != 0) begin
                t = rt + bitv;
                if (t * t <= n) rt = t;
                bitv >>= 1;
            end
            root = $signed(rt);
            f = 1;
            for (int k = 1; k <= am; k++) begin
                pmm = neg_s(mulk(mulq(pmm, root), f));
                f += 2;
            end
        end
        if (l == am) begin
            r.v = pmm;
        end else begin
            p1 = mulk(mulq(pmm, x), 2 * am + 1);
            for (int k = am + 2; k <= l; k++) begin
                ta = mulk(mulq(p1, x), 2 * k - 1);
                tb = mulk(pmm, k + am - 1);
                p = divk(subs(ta, tb), k - am);
                pmm = p1;
                p1 = p;
            end
            r.v = p1;
        end
        if (m <= 0) begin
            r.v = divk(r.v, fact(l + am) / fact(l - am));
            if (am[0]) r.v = neg_s(r.v);
        end
        return r;
    endfunction

    // driver: bursts and gaps, payload held until accepted
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || acc_seen) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (arg_q.size() > 0 && !hold_tx) begin
                    ale_arg_t a;
                    a = arg_q.pop_front();
                    s_degree <= a.l;
                    s_order <= a.m;
                    s_x_value <= a.x;
                    s_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
            case ($urandom_range(0, 3))
                0: m_ready <= 1'b0;
                default: m_ready <= ($urandom_range(0, 31) < 28);
            endcase
        end
    end

    // monitor: input beats feed the expected queue, result beats are checked
    always @(posedge aclk) begin
        acc_seen <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            legendre_q.push_back(legendre_value('{s_degree, s_order, s_x_value}));
        end
        if (aresetn && m_valid && m_ready) begin
            if (legendre_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_poly_value);
            end else begin
                ale_res_t e;
                e = legendre_q.pop_front();
                if (e.v !== m_poly_value || e.bad !== m_bad_args) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b got %h/%b",
                                 e.v, e.bad, m_poly_value, m_bad_args);
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_x();
        logic signed [31:0] x;
        case ($urandom_range(0, 9))
            0: x = $urandom();
            1: x = 32'sh4000_0000;
            2: x = -32'sh4000_0000;
            3: x = $urandom_range(0, 3) - 1 + ($urandom_range(0, 1) ? 32'sh4000_0000
                                                                   : -32'sh4000_0000);
            default: x = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
        endcase
        return x;
    endfunction

    initial begin
        ale_arg_t a;
        int lv;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        arg_q.push_back('{4'd0, 5'sd0, 32'sd0});
        arg_q.push_back('{4'd8, 5'sd8, 32'sd0});
        arg_q.push_back('{4'd8, -5'sd8, 32'sd0});
        arg_q.push_back('{4'd8, 5'sd0, 32'sh4000_0000});
        arg_q.push_back('{4'd8, 5'sd0, -32'sh4000_0000});
        arg_q.push_back('{4'd8, 5'sd3, 32'sh4000_0000});
        arg_q.push_back('{4'd8, 5'sd3, 32'sh4000_0001});
        arg_q.push_back('{4'd8, 5'sd1, -32'sh4000_0001});
        arg_q.push_back('{4'd8, 5'sd0, 32'sh7FFF_FFFF});
        arg_q.push_back('{4'd8, 5'sd0, 32'sh8000_0000});
        arg_q.push_back('{4'd3, 5'sd4, 32'sd5});
        arg_q.push_back('{4'd3, -5'sd4, 32'sd5});
        arg_q.push_back('{4'd2, 5'sd15, 32'sd5});
        arg_q.push_back('{4'd2, -5'sd16, 32'sd5});
        arg_q.push_back('{4'd9, 5'sd0, 32'sd5});
        arg_q.push_back('{4'd15, 5'sd1, 32'sd5});
        arg_q.push_back('{4'd5, -5'sd2, 32'sh2000_0000});
        arg_q.push_back('{4'd7, 5'sd2, -32'sh3000_0000});
        arg_q.push_back('{4'd1, -5'sd1, 32'sh1234_5678});
        arg_q.push_back('{4'd6, 5'sd0, 32'sh0000_0001});
        for (int i = 0; i < 550; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                a.l = $urandom();
                a.m = $urandom();
                a.x = $urandom();
            end else begin
                lv = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
                a.l = lv;
                a.m = $signed($urandom_range(0, 2 * lv)) - lv;
                a.x = rand_x();
            end
            arg_q.push_back(a);
            if (i == 275) begin
                // drain mid-run before continuing
                while (arg_q.size() > 0) @(posedge aclk);
                hold_tx = 1;
                while (s_valid || legendre_q.size() > 0) @(posedge aclk);
                hold_tx = 0;
            end
        end
        while (arg_q.size() > 0 || s_valid || legendre_q.size() > 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && legendre_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ale_pkg.sv
design/ale_datapath.sv
design/ale_ctrl.sv
design/associated_legendre_eval.sv
tb/testbench.sv
